@@ sv/wse_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and register indexes of the wheel speed estimator.
// No dependencies.
package wse_pkg;

	localparam int RING_DEPTH = 16;
	localparam int RING_LOG   = $clog2(RING_DEPTH);
	localparam int SUM_W      = 16 + RING_LOG;
	localparam int PROD_W     = 48;
	localparam int DIVR_W     = 32;
	localparam int MUL_STEPS  = 16;

	typedef logic [RING_LOG-1:0] ring_idx_t;
	typedef logic [SUM_W-1:0]    ring_sum_t;
	typedef logic [2:0]          cfg_idx_t;

	localparam cfg_idx_t CFG_MODE    = 3'd0;
	localparam cfg_idx_t CFG_LOCK_EN = 3'd1;
	localparam cfg_idx_t CFG_NUM     = 3'd2;
	localparam cfg_idx_t CFG_MAX     = 3'd3;
	localparam cfg_idx_t CFG_REFRESH = 3'd4;

	localparam logic [1:0]  MODE_RESET    = 2'd2;
	localparam logic [31:0] NUM_RESET     = 32'd460800000;
	localparam logic [15:0] MAX_RESET     = 16'd38400;
	localparam logic [19:0] REFRESH_RESET = 20'd50000;

	localparam logic [15:0] SPEED_MAX      = 16'hFFFF;
	localparam logic [16:0] CLAMP_BAND     = 17'd2560;
	localparam logic [15:0] LOCK_MIN_SPEED = 16'd5120;
	localparam logic [31:0] STANDSTILL_US  = 32'd1000000;
	localparam logic [31:0] HOLD_US        = 32'd1000000;
	localparam logic [31:0] LOCK_SHOW_US   = 32'd500000;
	localparam logic [31:0] UPTIME_US      = 32'd2000000;
	localparam logic [31:0] LOCK_GAP_OW    = 32'd40000;
	localparam logic [31:0] LOCK_GAP_HOLD  = 32'd50000;

	// handshake between the sequencer and a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

@@ sv/wheel_speed_estimator.sv @@
`timescale 1ns / 1ps
// Wheel speed estimator top level: event sequencer, ring average, registers.
// Depends on wse_pkg, wse_mul, wse_div.
//
//  channel | signals                              | role
//  in      | in_valid, in_ready, kind, time_us    | hall pulse or update tick
//  out     | out_valid, out_ready, avg_speed,     | one result per tick
//          | wheel_locked                         |
//  cfg     | cfg_valid, cfg_ready, cfg_index,     | register writes, always ready
//          | cfg_data                             |
//
// A pulse is taken in S_IDLE, which it does not leave. A tick with pending pulses runs the
// multiplier, divider and S_CLAMP, or only S_CLAMP if no time has elapsed since the handled pulse.
// A lock-check tick runs the divider, any other tick neither; S_AVG is added when the ring is due.
// Reset clears control state and ring, loads register defaults, not output data; no clearing pass.
// A result waiting in the output register stalls the next tick only at its last step.
module wheel_speed_estimator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [31:0] time_us,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] avg_speed,
	output logic        wheel_locked,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import wse_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_DIV, S_CLAMP, S_LOCKDIV, S_REFRESH, S_AVG, S_OUT
	} state_t;

	state_t state_q;

	logic [1:0]  mode_q;
	logic        lock_en_q;
	logic [31:0] num_q;
	logic [15:0] max_q;
	logic [19:0] refresh_per_q;

	logic [15:0] pending_q;
	logic [31:0] last_pulse_q;
	logic [31:0] handled_q;
	logic [15:0] interval_q;
	logic [15:0] avg_q;
	logic [15:0] held_q;
	logic [31:0] held_time_q;
	logic [31:0] refresh_time_q;
	logic [31:0] lock_check_q;
	logic [31:0] lock_time_q;
	logic [15:0] ring_q [RING_DEPTH];
	ring_sum_t   ring_sum_q;
	ring_idx_t   ring_pos_q;
	logic [31:0] now_q;
	logic [31:0] dur_q;
	logic        out_valid_q;
	logic [15:0] out_avg_q;
	logic        out_lock_q;

	logic        hold_mode;
	logic        clamp_mode;
	logic        in_xfer;
	logic [31:0] dur;
	logic        lock_go;
	logic        mul_start;
	logic        div_start;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] quo;
	logic [PROD_W-1:0] div_dividend;
	logic [DIVR_W-1:0] div_divisor;
	unit_stat_t  mul_stat;
	unit_stat_t  div_stat;
	logic [34:0] lock_limit;
	logic [16:0] clamp_hi;
	logic [15:0] clamp_lo;
	logic [15:0] ring_new;
	logic        out_free;

	assign hold_mode  = mode_q[1];
	assign clamp_mode = mode_q[0];
	assign in_ready   = (state_q == S_IDLE);
	assign cfg_ready  = 1'b1;
	assign in_xfer    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;

	assign dur = hold_mode ? (last_pulse_q - handled_q) : (time_us - handled_q);
	assign lock_go = lock_en_q && (avg_q > LOCK_MIN_SPEED) &&
		((time_us - lock_check_q) > (hold_mode ? LOCK_GAP_HOLD : LOCK_GAP_OW));

	assign mul_start = (state_q == S_IDLE) && in_xfer && kind && (pending_q != 16'd0)
		&& (dur != 32'd0);
	assign div_start = ((state_q == S_IDLE) && in_xfer && kind && (pending_q == 16'd0)
		&& lock_go) || ((state_q == S_MUL) && mul_stat.done);

	assign div_dividend = (state_q == S_IDLE) ? {16'b0, num_q} : prod;
	assign div_divisor  = (state_q == S_IDLE) ? {16'b0, avg_q} : dur_q;

	// limit = period * 7/2 or 5/2, truncated
	always_comb begin
		logic [34:0] p;
		p = {3'b0, quo[31:0]};
		lock_limit = hold_mode ? (((p << 3) - p) >> 1) : (((p << 2) + p) >> 1);
	end

	assign clamp_hi = ({1'b0, avg_q} + CLAMP_BAND > {1'b0, SPEED_MAX}) ?
		{1'b0, SPEED_MAX} : {1'b0, avg_q} + CLAMP_BAND;
	assign clamp_lo = ({1'b0, avg_q} > CLAMP_BAND) ? 16'(({1'b0, avg_q}) - CLAMP_BAND) : 16'd0;

	always_comb begin
		if (interval_q != 16'd0)
			ring_new = interval_q;
		else if (held_q != 16'd0 && (now_q - held_time_q) < HOLD_US)
			ring_new = held_q;
		else
			ring_new = 16'd0;
	end

	wse_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand_a (pending_q),
		.mcand_b (num_q),
		.stat    (mul_stat),
		.product (prod)
	);

	wse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_RESET;
			lock_en_q     <= 1'b0;
			num_q         <= NUM_RESET;
			max_q         <= MAX_RESET;
			refresh_per_q <= REFRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE:    mode_q        <= cfg_data[1:0];
				CFG_LOCK_EN: lock_en_q     <= cfg_data[0];
				CFG_NUM:     num_q         <= cfg_data;
				CFG_MAX:     max_q         <= cfg_data[15:0];
				CFG_REFRESH: refresh_per_q <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++) ring_q[i] <= '0;
		end else if (state_q == S_REFRESH &&
				(now_q - refresh_time_q) >= {12'b0, refresh_per_q}) begin
			ring_q[ring_pos_q] <= ring_new;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_avg_q  <= avg_q;
			out_lock_q <= (now_q > UPTIME_US) && ((now_q - lock_time_q) < LOCK_SHOW_US);
		end
		if (mul_start) dur_q <= dur;
		if (in_xfer) now_q <= time_us;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			pending_q      <= '0;
			last_pulse_q   <= '0;
			handled_q      <= '0;
			interval_q     <= '0;
			avg_q          <= '0;
			held_q         <= '0;
			held_time_q    <= '0;
			refresh_time_q <= '0;
			lock_check_q   <= '0;
			lock_time_q    <= '0;
			ring_sum_q     <= '0;
			ring_pos_q     <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_xfer && !kind) begin
						if (pending_q != SPEED_MAX) pending_q <= pending_q + 16'd1;
						last_pulse_q <= time_us;
					end else if (in_xfer) begin
						if (pending_q != 16'd0) begin
							handled_q    <= last_pulse_q;
							pending_q    <= '0;
							lock_check_q <= time_us;
							if (dur != 32'd0) begin
								state_q <= S_MUL;
							end else begin
								// outside hold mode, zero elapsed time counts as infinite speed
								if (!hold_mode) interval_q <= SPEED_MAX;
								state_q <= S_CLAMP;
							end
						end else if (lock_go) begin
							state_q <= S_LOCKDIV;
						end else begin
							if ((time_us - handled_q) > STANDSTILL_US) begin
								interval_q   <= '0;
								lock_check_q <= time_us;
							end
							state_q <= S_REFRESH;
						end
					end
				end
				S_MUL: begin
					if (mul_stat.done) state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						if (hold_mode) begin
							if (quo <= {32'b0, max_q} && quo[15:0] > interval_q)
								interval_q <= quo[15:0];
						end else begin
							interval_q <= (quo > {32'b0, SPEED_MAX}) ? SPEED_MAX : quo[15:0];
						end
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					if (clamp_mode) begin
						if ({1'b0, interval_q} > clamp_hi)
							interval_q <= clamp_hi[15:0];
						else if (interval_q < clamp_lo)
							interval_q <= clamp_lo;
					end
					state_q <= S_REFRESH;
				end
				S_LOCKDIV: begin
					if (div_stat.done) begin
						if ({3'b0, now_q - handled_q} > lock_limit) begin
							lock_time_q  <= now_q;
							lock_check_q <= now_q;
						end
						state_q <= S_REFRESH;
					end
				end
				S_REFRESH: begin
					if ((now_q - refresh_time_q) >= {12'b0, refresh_per_q}) begin
						refresh_time_q <= now_q;
						if (interval_q != 16'd0) begin
							held_q      <= interval_q;
							held_time_q <= now_q;
						end
						ring_sum_q <= ring_sum_q - ring_sum_t'(ring_q[ring_pos_q])
							+ ring_sum_t'(ring_new);
						interval_q <= '0;
						ring_pos_q <= (ring_pos_q == ring_idx_t'(RING_DEPTH - 1)) ?
							'0 : ring_pos_q + ring_idx_t'(1);
						state_q <= S_AVG;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_AVG: begin
					avg_q   <= ring_sum_q[SUM_W-1:RING_LOG];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign avg_speed    = out_avg_q;
	assign wheel_locked = out_lock_q;

`ifndef NO_ASSERTIONS
	a_units_idle_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !mul_stat.busy && !div_stat.busy)
		else $error("arithmetic unit busy while taking items");
	a_result_from_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output step");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");
	a_mul_then_div: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |=> div_stat.busy)
		else $error("division did not follow multiplication");
`endif

endmodule

@@ sv/wse_mul.sv @@
`timescale 1ns / 1ps
// Shift-add multiplier: 16-bit pulse count times 32-bit numerator, one bit per cycle.
// Depends on wse_pkg.
module wse_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [15:0]                 mcand_a,
	input  logic [31:0]                 mcand_b,
	output wse_pkg::unit_stat_t         stat,
	output logic [wse_pkg::PROD_W-1:0]  product
);
	import wse_pkg::*;

	logic [15:0]       a_q;
	logic [PROD_W-1:0] b_q;
	logic [PROD_W-1:0] acc_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(MUL_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= mcand_a;
			b_q   <= {16'b0, mcand_b};
			acc_q <= '0;
		end else if (busy_q) begin
			if (a_q[0]) acc_q <= acc_q + b_q;
			a_q <= {1'b0, a_q[15:1]};
			b_q <= {b_q[PROD_W-2:0], 1'b0};
		end
	end

	assign product   = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

@@ sv/wse_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle (48-bit dividend, 32-bit divisor).
// Depends on wse_pkg.
module wse_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wse_pkg::PROD_W-1:0]  dividend,
	input  logic [wse_pkg::DIVR_W-1:0]  divisor,
	output wse_pkg::unit_stat_t         stat,
	output logic [wse_pkg::PROD_W-1:0]  quotient
);
	import wse_pkg::*;

	logic [PROD_W-1:0] quo_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] dvs_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVR_W:0]   shifted;
	logic [DIVR_W+1:0] diff;
	logic              ge;

	assign shifted = {rem_q, quo_q[PROD_W-1]};
	assign diff    = {1'b0, shifted} - {2'b0, dvs_q};
	assign ge      = !diff[DIVR_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
